// ===== hdl/rau_pkg.sv =====
`default_nettype none
package rau_pkg;
  localparam logic [3:0] FN_ADD = 4'd0;
  localparam logic [3:0] FN_SUB = 4'd1;
  localparam logic [3:0] FN_MUL = 4'd2;
  localparam logic [3:0] FN_DIV = 4'd3;
  localparam logic [3:0] FN_GT  = 4'd4;
  localparam logic [3:0] FN_LT  = 4'd5;
  localparam logic [3:0] FN_LE  = 4'd6;
  localparam logic [3:0] FN_GE  = 4'd7;
  localparam logic [3:0] FN_EQ  = 4'd8;

  localparam int ResNumBits = 32;
  localparam int ResDenBits = 31;

  // operation class decided by the front end
  typedef struct packed {
    logic arith;
    logic cmp;
    logic sub;
    logic mul;
    logic div;
  } op_class_t;

  // result beat
  typedef struct packed {
    logic [ResNumBits-1:0] num;
    logic [ResDenBits-1:0] den;
    logic                  cmp_true;
    logic                  div_zero;
  } result_t;
endpackage
`default_nettype wire

// ===== hdl/rau_front.sv =====
`default_nettype none
module rau_front #(
  parameter int W = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [3:0]           func,
  input  wire logic signed [W-1:0]  a_num,
  input  wire logic [W-2:0]         a_den,
  input  wire logic signed [W-1:0]  b_num,
  input  wire logic [W-2:0]         b_den,
  output logic                      q_valid,
  input  wire logic                 q_ready,
  output rau_pkg::op_class_t        q_cls,
  output logic [3:0]                q_func,
  output logic signed [W-1:0]       q_an,
  output logic [W-2:0]              q_ad,
  output logic signed [W-1:0]       q_bn,
  output logic [W-2:0]              q_bd
);
  // classification of the incoming beat
  rau_pkg::op_class_t cls;
  always_comb begin
    cls = '0;
    unique case (func)
      rau_pkg::FN_ADD: cls.arith = 1'b1;
      rau_pkg::FN_SUB: begin cls.arith = 1'b1; cls.sub = 1'b1; end
      rau_pkg::FN_MUL: begin cls.arith = 1'b1; cls.mul = 1'b1; end
      rau_pkg::FN_DIV: begin cls.arith = 1'b1; cls.div = 1'b1; end
      rau_pkg::FN_GT, rau_pkg::FN_LT, rau_pkg::FN_LE, rau_pkg::FN_GE,
      rau_pkg::FN_EQ: cls.cmp = 1'b1;
      default: cls = '0;
    endcase
  end

  // two-entry queue towards the back end
  logic [1:0] cnt;
  logic       wp, rp;
  rau_pkg::op_class_t qc [2];
  logic [3:0]         qf [2];
  logic signed [W-1:0] qan [2], qbn [2];
  logic [W-2:0]        qad [2], qbd [2];

  assign in_ready = (cnt != 2'd2);
  assign q_valid  = (cnt != 2'd0);
  wire do_push = in_valid && in_ready;
  wire do_pop  = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      wp  <= 1'b0;
      rp  <= 1'b0;
    end else begin
      if (do_push) wp <= ~wp;
      if (do_pop) rp <= ~rp;
      cnt <= cnt + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      qc[wp]  <= cls;
      qf[wp]  <= func;
      qan[wp] <= a_num;
      qad[wp] <= a_den;
      qbn[wp] <= b_num;
      qbd[wp] <= b_den;
    end
  end

  assign q_cls  = qc[rp];
  assign q_func = qf[rp];
  assign q_an   = qan[rp];
  assign q_ad   = qad[rp];
  assign q_bn   = qbn[rp];
  assign q_bd   = qbd[rp];
endmodule
`default_nettype wire

// ===== hdl/rau_back.sv =====
`default_nettype none
module rau_back #(
  parameter int W = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                q_valid,
  output logic                     q_ready,
  input  wire rau_pkg::op_class_t  q_cls,
  input  wire logic [3:0]          q_func,
  input  wire logic signed [W-1:0] q_an,
  input  wire logic [W-2:0]        q_ad,
  input  wire logic signed [W-1:0] q_bn,
  input  wire logic [W-2:0]        q_bd,
  output logic                     r_valid,
  input  wire logic                r_pop,
  output rau_pkg::result_t         r_data
);
  localparam int PW = 2 * W;       // product width
  localparam int NW = PW + 1;      // signed sum width
  localparam int MW = PW;          // magnitude width
  localparam int CW = $clog2(MW + 1) + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_GCD  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state;
  rau_pkg::op_class_t cls;
  logic [3:0]          fn;
  logic signed [W-1:0] an, bn;
  logic [W-2:0]        ad, bd;
  logic signed [PW-1:0] p0, p1;     // an*bd or an*bn, ad*bn
  logic [PW-1:0]        pd;         // ad*bd
  logic [MW-1:0] gx, gy, nm, dm, qt, rm;
  logic [CW-1:0] sh, bitc;
  logic          neg, divn;

  // products against signed extended operands
  wire signed [W:0] ad_s = {2'b00, ad};
  wire signed [W:0] bd_s = {2'b00, bd};
  wire signed [PW+1:0] m0 = cls.mul ? an * bn : an * bd_s;
  wire signed [PW+1:0] m1 = bn * ad_s;

  wire signed [NW-1:0] sum_n =
    cls.mul || cls.div ? NW'(p0) :
    cls.sub ? NW'(p0) - NW'(p1) : NW'(p0) + NW'(p1);
  wire signed [NW:0] dsg = cls.div ? (NW+1)'(p1) : (NW+1)'({1'b0, pd});

  // comparison of cross products
  logic cmp_t;
  always_comb begin
    case (fn)
      rau_pkg::FN_GT: cmp_t = p0 > p1;
      rau_pkg::FN_LT: cmp_t = p0 < p1;
      rau_pkg::FN_LE: cmp_t = p0 <= p1;
      rau_pkg::FN_GE: cmp_t = p0 >= p1;
      default:        cmp_t = p0 == p1;
    endcase
  end

  // restoring divide step
  wire [MW:0] rsh   = {rm, nm[MW-1]};
  wire        fits  = rsh >= {1'b0, gx};

  assign q_ready = (state == S_IDLE) && !r_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      r_valid <= 1'b0;
    end else begin
      if (r_valid && r_pop) r_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (q_valid && q_ready) begin
          cls <= q_cls; fn <= q_func;
          an <= q_an; ad <= q_ad; bn <= q_bn; bd <= q_bd;
          state <= S_MUL;
        end
        // one multiplier rank
        S_MUL: begin
          p0 <= PW'(m0);
          p1 <= PW'(m1);
          pd <= PW'(ad * bd);
          state <= S_SUM;
        end
        // form numerator and denominator, or finish compares, unused codes and zero denominators
        S_SUM: begin
          if (!cls.arith) begin
            r_data.num <= '0;
            r_data.den <= '0;
            r_data.cmp_true <= cls.cmp ? cmp_t : 1'b0;
            r_data.div_zero <= 1'b0;
            r_valid <= 1'b1;
            state <= S_IDLE;
          end else if (dsg == '0) begin
            r_data.num <= '0;
            r_data.den <= '0;
            r_data.cmp_true <= 1'b0;
            r_data.div_zero <= 1'b1;
            r_valid <= 1'b1;
            state <= S_IDLE;
          end else begin
            neg <= sum_n[NW-1] ^ dsg[NW];
            nm  <= MW'(sum_n[NW-1] ? -sum_n : sum_n);
            dm  <= MW'(dsg[NW] ? -dsg : dsg);
            gx  <= MW'(sum_n[NW-1] ? -sum_n : sum_n);
            gy  <= MW'(dsg[NW] ? -dsg : dsg);
            sh  <= '0;
            state <= S_GCD;
          end
        end
        // binary gcd, one step per cycle
        S_GCD: begin
          if (gx == '0) begin
            gx <= gy << sh; state <= S_DIV; divn <= 1'b0; bitc <= '0;
            rm <= '0; qt <= '0;
          end else if (gy == '0) begin
            gx <= gx << sh; state <= S_DIV; divn <= 1'b0; bitc <= '0;
            rm <= '0; qt <= '0;
          end else if (!gx[0] && !gy[0]) begin
            gx <= gx >> 1; gy <= gy >> 1; sh <= sh + 1'b1;
          end else if (!gx[0]) gx <= gx >> 1;
          else if (!gy[0]) gy <= gy >> 1;
          else if (gx >= gy) gx <= (gx - gy) >> 1;
          else gy <= (gy - gx) >> 1;
        end
        // divide numerator then denominator by the gcd, one bit per cycle
        S_DIV: begin
          qt <= {qt[MW-2:0], fits};
          if (bitc == CW'(MW - 1)) begin
            bitc <= '0;
            rm <= '0;
            nm <= dm;
            dm <= {qt[MW-2:0], fits};
            divn <= 1'b1;
            if (divn) state <= S_OUT;
          end else begin
            bitc <= bitc + 1'b1;
            rm <= fits ? MW'(rsh - {1'b0, gx}) : MW'(rsh);
            nm <= nm << 1;
          end
        end
        S_OUT: begin
          r_data.num <= rau_pkg::ResNumBits'((neg && nm != '0) ? -nm : nm);
          r_data.den <= rau_pkg::ResDenBits'(dm);
          r_data.cmp_true <= 1'b0;
          r_data.div_zero <= 1'b0;
          r_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== hdl/rational_arith_unit.sv =====
`default_nettype none
// rational arithmetic unit: add, sub, mul, div of two fractions, reduced
// to lowest terms, plus five comparisons by cross-multiplication
// input channel: push/full; a beat is taken when push is high and full low
// result channel: empty/pop; the head result sits on the result ports while
// empty is low and leaves when pop is high
// a two-entry queue parts the classifying front end from the execution
// back end, so up to two further beats are taken while one is at work
// compares and errors finish in the sum state after the multiplier rank;
// arithmetic runs on through the gcd steps and the divide steps for the
// numerator and then the denominator before the output state
// the back end takes no new item until its last result has left, as the
// single serial gcd/divide unit in the back end serves one item at a time
// reset clears the queue and the result valid flag; held results wait as
// long as pop stays low and the back end then stalls
module rational_arith_unit #(
  parameter int OPERAND_BITS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           push,
  output logic                                full,
  input  wire logic [3:0]                     func,
  input  wire logic signed [OPERAND_BITS-1:0] a_num,
  input  wire logic [OPERAND_BITS-2:0]        a_den,
  input  wire logic signed [OPERAND_BITS-1:0] b_num,
  input  wire logic [OPERAND_BITS-2:0]        b_den,
  output logic                                empty,
  input  wire logic                           pop,
  output logic signed [31:0]                  res_num,
  output logic [30:0]                         res_den,
  output logic                                cmp_true,
  output logic                                div_zero
);
  localparam int W = OPERAND_BITS;

  logic q_valid, q_ready, in_ready, r_valid;
  rau_pkg::op_class_t q_cls;
  logic [3:0] q_func;
  logic signed [W-1:0] q_an, q_bn;
  logic [W-2:0] q_ad, q_bd;
  rau_pkg::result_t r_data;

  // front end and queue
  rau_front #(.W(W)) u_front (
    .clk, .rst, .in_valid(push), .in_ready, .func, .a_num, .a_den,
    .b_num, .b_den, .q_valid, .q_ready, .q_cls, .q_func, .q_an, .q_ad,
    .q_bn, .q_bd
  );

  // execution back end
  rau_back #(.W(W)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_cls, .q_func, .q_an, .q_ad,
    .q_bn, .q_bd, .r_valid, .r_pop(pop), .r_data
  );

  assign full     = !in_ready;
  assign empty    = !r_valid;
  assign res_num  = r_data.num;
  assign res_den  = r_data.den;
  assign cmp_true = r_data.cmp_true;
  assign div_zero = r_data.div_zero;

`ifndef ASSERT_OFF
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    !empty |-> !(cmp_true && div_zero)) else $error("cmp and error both set");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && div_zero) |-> (res_den == '0)) else $error("error with den");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(res_num) && $stable(res_den)))
    else $error("result changed while held");
`endif
endmodule
`default_nettype wire

// ===== tb/tb_rational_arith_unit.sv =====
`default_nettype none
module tb_rational_arith_unit;

  localparam int OPB = 16;
  localparam int N_RANDOM = 1530;
  localparam longint CYCLE_LIMIT = 2500000;
  localparam int LONG_HOLD = 800;

  typedef struct {
    logic [3:0]            fn;
    logic signed [OPB-1:0] an;
    logic [OPB-2:0]        ad;
    logic signed [OPB-1:0] bn;
    logic [OPB-2:0]        bd;
    bit                    typed;
    rau_pkg::result_t      res;
  } vec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic [3:0] func = '0;
  logic signed [OPB-1:0] a_num = '0;
  logic [OPB-2:0] a_den = '0;
  logic signed [OPB-1:0] b_num = '0;
  logic [OPB-2:0] b_den = '0;
  logic full, empty, cmp_true, div_zero;
  logic signed [31:0] res_num;
  logic [30:0] res_den;

  rau_pkg::result_t expected_results[$];
  int errors = 0;
  int beats_in = 0;
  int beats_out = 0;
  longint cycles = 0;
  bit hold_long = 1'b0;
  bit hold_done = 1'b0;
  vec_t directed[$];

  rational_arith_unit #(.OPERAND_BITS(OPB)) DUT (
    .clk(clk), .rst(rst), .push(push), .full(full), .func(func),
    .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
    .empty(empty), .pop(pop), .res_num(res_num), .res_den(res_den),
    .cmp_true(cmp_true), .div_zero(div_zero)
  );

  always #10 clk = ~clk;

  // euclid on magnitudes
  function automatic longint unsigned gcd_of(longint unsigned x, longint unsigned y);
    longint unsigned t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // exact fraction result for one item
  function automatic rau_pkg::result_t reduce_fraction(
      logic [3:0] fn, logic signed [OPB-1:0] an, logic [OPB-2:0] ad,
      logic signed [OPB-1:0] bn, logic [OPB-2:0] bd);
    longint n, d, l, r, sa, sb, ua, ub;
    longint unsigned nm, dm, g;
    bit neg;
    rau_pkg::result_t o;
    sa = an;
    sb = bn;
    ua = {1'b0, ad};
    ub = {1'b0, bd};
    o = '0;
    if (fn <= rau_pkg::FN_DIV) begin
      case (fn)
        rau_pkg::FN_ADD: begin n = sa * ub + ua * sb; d = ua * ub; end
        rau_pkg::FN_SUB: begin n = sa * ub - ua * sb; d = ua * ub; end
        rau_pkg::FN_MUL: begin n = sa * sb; d = ua * ub; end
        default:         begin n = sa * ub; d = ua * sb; end
      endcase
      if (d == 0) begin
        o.div_zero = 1'b1;
      end else begin
        neg = (n < 0) != (d < 0);
        nm = (n < 0) ? -n : n;
        dm = (d < 0) ? -d : d;
        g = gcd_of(nm, dm);
        nm = nm / g;
        dm = dm / g;
        if (nm == 0) neg = 1'b0;
        o.num = 32'(neg ? -nm : nm);
        o.den = dm[30:0];
      end
    end else if (fn <= rau_pkg::FN_EQ) begin
      l = sa * ub;
      r = sb * ua;
      case (fn)
        rau_pkg::FN_GT: o.cmp_true = l > r;
        rau_pkg::FN_LT: o.cmp_true = l < r;
        rau_pkg::FN_LE: o.cmp_true = l <= r;
        rau_pkg::FN_GE: o.cmp_true = l >= r;
        default:        o.cmp_true = l == r;
      endcase
    end
    return o;
  endfunction

  function automatic vec_t row(logic [3:0] fn, int an, int ad, int bn, int bd,
                               bit typed = 0, int rn = 0, int rd = 0,
                               bit c = 0, bit z = 0);
    vec_t v;
    v.fn = fn; v.an = OPB'(an); v.ad = (OPB-1)'(ad);
    v.bn = OPB'(bn); v.bd = (OPB-1)'(bd);
    v.typed = typed;
    v.res.num = rn; v.res.den = 31'(rd); v.res.cmp_true = c; v.res.div_zero = z;
    return v;
  endfunction

  // offer one beat after a random gap, wait for it to be taken
  task automatic send_beat(vec_t v, bit gaps);
    int gap;
    rau_pkg::result_t e;
    gap = gaps ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    func <= v.fn; a_num <= v.an; a_den <= v.ad; b_num <= v.bn; b_den <= v.bd;
    e = reduce_fraction(v.fn, v.an, v.ad, v.bn, v.bd);
    if (v.typed && e !== v.res) begin
      $display("%0t table row disagrees: func %0d expected %p predicted %p",
               $time, v.fn, v.res, e);
      errors++;
    end
    expected_results.push_back(v.typed ? v.res : e);
    do @(posedge clk); while (full);
    beats_in++;
  endtask

  function automatic logic signed [OPB-1:0] rand_num();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      1: return $signed(16'($urandom_range(0, 12))) - 16'sd6;
      default: return $signed(16'($urandom));
    endcase
  endfunction

  function automatic logic [OPB-2:0] rand_den();
    case ($urandom_range(0, 9))
      0: return 15'h7fff;
      1: return 15'd0;
      2, 3: return 15'($urandom_range(1, 12));
      default: return 15'($urandom_range(1, 32767));
    endcase
  endfunction

  // result side: pop with random stalls, check against oldest expectation
  initial begin : receiver
    int stall;
    rau_pkg::result_t e;
    @(negedge rst);
    forever begin
      if (hold_long && !hold_done) begin
        pop <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1'b1;
      end
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      beats_out++;
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result beat: num %0d den %0d cmp %b dz %b",
                 $time, res_num, res_den, cmp_true, div_zero);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (res_num !== e.num) begin
          $display("%0t res_num expected %0d actual %0d", $time,
                   $signed(e.num), res_num);
          errors++;
        end
        if (res_den !== e.den) begin
          $display("%0t res_den expected %0d actual %0d", $time, e.den, res_den);
          errors++;
        end
        if (cmp_true !== e.cmp_true) begin
          $display("%0t cmp_true expected %b actual %b", $time, e.cmp_true, cmp_true);
          errors++;
        end
        if (div_zero !== e.div_zero) begin
          $display("%0t div_zero expected %b actual %b", $time, e.div_zero, div_zero);
          errors++;
        end
      end
    end
  end

  // run-length guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : sender
    vec_t v;
    int n;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed table: extremes, every operation, special cases
    directed.push_back(row(rau_pkg::FN_ADD, 0, 1, 0, 1, 1, 0, 1));
    directed.push_back(row(rau_pkg::FN_ADD, 1, 2, 1, 3));
    directed.push_back(row(rau_pkg::FN_SUB, 1, 2, 1, 2, 1, 0, 1));
    directed.push_back(row(rau_pkg::FN_SUB, -32768, 32767, 32767, 1));
    directed.push_back(row(rau_pkg::FN_MUL, -32768, 1, -32768, 1, 1, 1073741824, 1));
    directed.push_back(row(rau_pkg::FN_MUL, 32767, 32767, -32768, 32767));
    directed.push_back(row(rau_pkg::FN_DIV, 3, 4, 0, 5, 1, 0, 0, 0, 1));
    directed.push_back(row(rau_pkg::FN_DIV, -32768, 1, 1, 32767));
    directed.push_back(row(rau_pkg::FN_DIV, 5, 0, 1, 1, 1, 0, 0, 0, 1));
    directed.push_back(row(rau_pkg::FN_ADD, 1, 0, 1, 3, 1, 0, 0, 0, 1));
    directed.push_back(row(rau_pkg::FN_MUL, 1, 3, 1, 0, 1, 0, 0, 0, 1));
    directed.push_back(row(rau_pkg::FN_SUB, 7, 0, 7, 0, 1, 0, 0, 0, 1));
    directed.push_back(row(rau_pkg::FN_GT, 1, 2, 1, 3, 1, 0, 0, 1));
    directed.push_back(row(rau_pkg::FN_LT, 1, 2, 1, 3, 1, 0, 0, 0));
    directed.push_back(row(rau_pkg::FN_LE, 2, 4, 1, 2, 1, 0, 0, 1));
    directed.push_back(row(rau_pkg::FN_GE, -32768, 1, 32767, 1, 1, 0, 0, 0));
    directed.push_back(row(rau_pkg::FN_EQ, 2, 4, 1, 2, 1, 0, 0, 1));
    directed.push_back(row(rau_pkg::FN_EQ, 1, 0, 5, 0));
    directed.push_back(row(rau_pkg::FN_LT, -1, 32767, 0, 0));
    directed.push_back(row(4'd9, 1, 1, 1, 1, 1, 0, 0, 0, 0));
    directed.push_back(row(4'd15, -1, 32767, -1, 32767, 1, 0, 0, 0, 0));
    directed.push_back(row(rau_pkg::FN_DIV, -6, 4, -3, 2, 1, 1, 1));
    directed.push_back(row(rau_pkg::FN_ADD, -32768, 32767, -32768, 32767));
    foreach (directed[i]) send_beat(directed[i], 1);
    push <= 1'b0;

    // pause until every result is home
    wait (expected_results.size() == 0);
    @(posedge clk);

    // random part; early on the receiver holds off so the block backs up
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 20) hold_long = 1'b1;
      n = $urandom_range(0, 15);
      v.fn = (n < 14) ? 4'(n % 9) : 4'($urandom_range(9, 15));
      v.an = rand_num(); v.bn = rand_num();
      v.ad = rand_den(); v.bd = rand_den();
      v.typed = 0;
      send_beat(v, !(hold_long && !hold_done) && (i % 200 > 30));
    end
    push <= 1'b0;

    wait (expected_results.size() == 0);
    repeat (400) @(posedge clk);
    $display("Sent %0d beats and checked %0d results over all nine operations,", beats_in,
             beats_out);
    $display("unused codes, zero denominators and operand extremes.");
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire
